@@ hw/rtl/priority_schedule_waiting_times_unit_defines.svh @@
// assertion helpers for the scheduler rtl
`ifndef PRIORITY_SCHEDULE_WAITING_TIMES_UNIT_DEFINES_SVH
`define PRIORITY_SCHEDULE_WAITING_TIMES_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PSW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/psw_pkg.sv @@
package psw_pkg;

  localparam int ID_W   = 8;
  localparam int TIME_W = 16;
  localparam int PRIO_W = 8;
  localparam int ACC_W  = 24;

  localparam logic [ACC_W-1:0] TIME_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [ID_W-1:0]   proc_id;
    logic [TIME_W-1:0] arrive_at;
    logic [TIME_W-1:0] run_length;
    logic [PRIO_W-1:0] prio_level;
    logic              is_last;
  } in_req_t;

  typedef struct packed {
    logic [ID_W-1:0]   out_id;
    logic [TIME_W-1:0] out_arrive;
    logic [TIME_W-1:0] out_run;
    logic [PRIO_W-1:0] out_prio;
    logic [ACC_W-1:0]  wait_ticks;
    logic [ACC_W-1:0]  turnaround_ticks;
    logic              dropped_flag;
    logic              end_of_run;
  } out_req_t;

  // one stored process record
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrive;
    logic [TIME_W-1:0] run;
    logic [PRIO_W-1:0] prio;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

@@ hw/rtl/priority_schedule_waiting_times_unit.sv @@
// load: one record per cycle; the table holds two batches, so a new batch loads while one schedules
// schedule: per result a full scan of the batch, then start, wait and finish time math
// scheduling is limited by one ram read port
// input stalls only while two batches are waiting or in work
// reset: synchronous active-low rst_n clears counters, queue and fsm; table contents stay undefined
module priority_schedule_waiting_times_unit #(
  parameter int MAX_PROCS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  psw_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output psw_pkg::out_req_t out_req
);

  localparam int IW  = $clog2(MAX_PROCS);
  localparam int CW  = $clog2(MAX_PROCS + 1);
  // two banks of the record table, one per batch in flight
  localparam int RAM_DEPTH = 2 * (1 << IW);
  // batch descriptor: bank, record count, overflow flag
  localparam int DW  = 1 + CW + 1;

  logic          q_full;
  logic          q_empty;
  logic          q_push;
  logic          q_pop;
  logic [DW-1:0] q_push_data;
  logic [DW-1:0] q_head;

  logic          push_bank;
  logic [CW-1:0] push_count;
  logic          push_ovf;

  logic          wr_en;
  logic [IW:0]   wr_addr;
  psw_pkg::rec_t wr_rec;
  logic          rd_en;
  logic [IW:0]   rd_addr;
  logic [psw_pkg::REC_W-1:0] rd_raw;
  psw_pkg::rec_t rd_rec;

  // front: takes records, writes the table, closes a batch on the last request
  psw_front #(.MAX_PROCS(MAX_PROCS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req     (in_req),
    .q_full     (q_full),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_rec),
    .push       (q_push),
    .push_bank  (push_bank),
    .push_count (push_count),
    .push_ovf   (push_ovf)
  );

  assign q_push_data = {push_bank, push_count, push_ovf};

  // closed batches for the scheduler; the head stays queued until its last result
  psw_queue #(.W(DW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // record table, registered read
  psw_ram #(.W(psw_pkg::REC_W), .DEPTH(RAM_DEPTH)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_rec),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_rec = rd_raw;

  // back: selection scan per result, running completion time, output register
  psw_back #(.MAX_PROCS(MAX_PROCS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_valid (!q_empty),
    .desc_bank  (q_head[DW-1]),
    .desc_count (q_head[CW:1]),
    .desc_ovf   (q_head[0]),
    .desc_pop   (q_pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_rec),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_req    (out_req)
  );

endmodule

@@ hw/rtl/psw_ram.sv @@
module psw_ram #(
  parameter int W     = 48,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [W-1:0]             wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [W-1:0]             rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/psw_queue.sv @@
module psw_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ hw/rtl/psw_front.sv @@
module psw_front #(
  parameter int MAX_PROCS = 16,
  localparam int IW = $clog2(MAX_PROCS),
  localparam int CW = $clog2(MAX_PROCS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  psw_pkg::in_req_t  in_req,
  input  logic              q_full,
  output logic              wr_en,
  output logic [IW:0]       wr_addr,
  output psw_pkg::rec_t     wr_data,
  output logic              push,
  output logic              push_bank,
  output logic [CW-1:0]     push_count,
  output logic              push_ovf
);

  logic          bank_r, bank_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          accept;
  logic          has_room;
  logic [CW-1:0] cnt_after;
  logic          ovf_after;

  // a free table bank exists whenever the batch queue is not full
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign has_room = (cnt_r < CW'(MAX_PROCS));

  assign wr_en   = accept && has_room;
  assign wr_addr = {bank_r, cnt_r[IW-1:0]};
  assign wr_data = '{id:     in_req.proc_id,
                     arrive: in_req.arrive_at,
                     run:    in_req.run_length,
                     prio:   in_req.prio_level};

  assign cnt_after = has_room ? cnt_r + CW'(1) : cnt_r;
  assign ovf_after = ovf_r || !has_room;

  assign push       = accept && in_req.is_last;
  assign push_bank  = bank_r;
  assign push_count = cnt_after;
  assign push_ovf   = ovf_after;

  always_comb begin
    bank_nxt = bank_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    if (accept) begin
      if (in_req.is_last) begin
        bank_nxt = ~bank_r;
        cnt_nxt  = '0;
        ovf_nxt  = 1'b0;
      end else begin
        cnt_nxt = cnt_after;
        ovf_nxt = ovf_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
    end else begin
      bank_r <= bank_nxt;
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

@@ hw/rtl/psw_back.sv @@
`include "priority_schedule_waiting_times_unit_defines.svh"

module psw_back #(
  parameter int MAX_PROCS = 16,
  localparam int IW = $clog2(MAX_PROCS),
  localparam int CW = $clog2(MAX_PROCS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              desc_valid,
  input  logic              desc_bank,
  input  logic [CW-1:0]     desc_count,
  input  logic              desc_ovf,
  output logic              desc_pop,
  output logic              rd_en,
  output logic [IW:0]       rd_addr,
  input  psw_pkg::rec_t     rd_data,
  output logic              out_valid,
  input  logic              out_ready,
  output psw_pkg::out_req_t out_req
);

  localparam int KW = psw_pkg::PRIO_W + psw_pkg::TIME_W + IW;
  localparam int AW = psw_pkg::ACC_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_CALC1, S_CALC2, S_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [IW-1:0]     issue_r, issue_nxt;
  logic              sv_r, sv_nxt;
  logic [IW-1:0]     sidx_r, sidx_nxt;
  logic [IW-1:0]     pos_r, pos_nxt;
  logic              has_last_r, has_last_nxt;
  logic [KW-1:0]     last_key_r, last_key_nxt;
  logic              best_vld_r, best_vld_nxt;
  logic [KW-1:0]     best_key_r, best_key_nxt;
  psw_pkg::rec_t     best_rec_r, best_rec_nxt;
  logic [AW-1:0]     finish_r, finish_nxt;
  logic [AW-1:0]     start_r, start_nxt;
  logic [AW-1:0]     wait_r, wait_nxt;
  logic              out_valid_r, out_valid_nxt;
  psw_pkg::out_req_t out_r, out_nxt;

  logic [CW-1:0] n_m1;
  logic [IW-1:0] last_idx;
  logic [KW-1:0] cand_key;
  logic          take;
  logic          can_emit;
  logic [AW-1:0] arrive_ext;
  logic [AW:0]   fin_sum;
  logic [AW:0]   tat_sum;

  assign n_m1     = desc_count - CW'(1);
  assign last_idx = n_m1[IW-1:0];

  // sort key: priority, then arrival, then load order
  assign cand_key = {rd_data.prio, rd_data.arrive, sidx_r};
  assign take = sv_r && (!has_last_r || (cand_key > last_key_r))
                     && (!best_vld_r || (cand_key < best_key_r));

  assign can_emit   = !out_valid_r || out_ready;
  assign arrive_ext = AW'(best_rec_r.arrive);
  assign fin_sum    = {1'b0, start_r} + (AW + 1)'(best_rec_r.run);
  assign tat_sum    = {1'b0, wait_r} + (AW + 1)'(best_rec_r.run);

  assign rd_en     = (state_r == S_SCAN);
  assign rd_addr   = {desc_bank, issue_r};
  assign desc_pop  = (state_r == S_EMIT) && can_emit && (pos_r == last_idx);
  assign out_valid = out_valid_r;
  assign out_req   = out_r;

  always_comb begin
    state_nxt     = state_r;
    issue_nxt     = issue_r;
    sv_nxt        = (state_r == S_SCAN);
    sidx_nxt      = issue_r;
    pos_nxt       = pos_r;
    has_last_nxt  = has_last_r;
    last_key_nxt  = last_key_r;
    best_vld_nxt  = best_vld_r;
    best_key_nxt  = best_key_r;
    best_rec_nxt  = best_rec_r;
    finish_nxt    = finish_r;
    start_nxt     = start_r;
    wait_nxt      = wait_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;

    if (take) begin
      best_vld_nxt = 1'b1;
      best_key_nxt = cand_key;
      best_rec_nxt = rd_data;
    end

    case (state_r)
      S_IDLE: begin
        if (desc_valid) begin
          state_nxt    = S_SCAN;
          issue_nxt    = '0;
          pos_nxt      = '0;
          has_last_nxt = 1'b0;
          best_vld_nxt = 1'b0;
          finish_nxt   = '0;
        end
      end
      S_SCAN: begin
        issue_nxt = issue_r + IW'(1);
        if (issue_r == last_idx) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_CALC1;
      end
      S_CALC1: begin
        start_nxt = (finish_r > arrive_ext) ? finish_r : arrive_ext;
        state_nxt = S_CALC2;
      end
      S_CALC2: begin
        wait_nxt   = start_r - arrive_ext;
        finish_nxt = fin_sum[AW] ? psw_pkg::TIME_MAX : fin_sum[AW-1:0];
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (can_emit) begin
          out_valid_nxt            = 1'b1;
          out_nxt.out_id           = best_rec_r.id;
          out_nxt.out_arrive       = best_rec_r.arrive;
          out_nxt.out_run          = best_rec_r.run;
          out_nxt.out_prio         = best_rec_r.prio;
          out_nxt.wait_ticks       = wait_r;
          out_nxt.turnaround_ticks = tat_sum[AW] ? psw_pkg::TIME_MAX : tat_sum[AW-1:0];
          out_nxt.dropped_flag     = desc_ovf;
          out_nxt.end_of_run       = (pos_r == last_idx);
          if (pos_r == last_idx) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt    = S_SCAN;
            pos_nxt      = pos_r + IW'(1);
            has_last_nxt = 1'b1;
            last_key_nxt = best_key_r;
            best_vld_nxt = 1'b0;
            issue_nxt    = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    sidx_nxt_hold: begin
      sidx_r     <= sidx_nxt;
      last_key_r <= last_key_nxt;
      best_key_r <= best_key_nxt;
      best_rec_r <= best_rec_nxt;
      start_r    <= start_nxt;
      wait_r     <= wait_nxt;
      out_r      <= out_nxt;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_r     <= '0;
      sv_r        <= 1'b0;
      pos_r       <= '0;
      has_last_r  <= 1'b0;
      best_vld_r  <= 1'b0;
      finish_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      sv_r        <= sv_nxt;
      pos_r       <= pos_nxt;
      has_last_r  <= has_last_nxt;
      best_vld_r  <= best_vld_nxt;
      finish_r    <= finish_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PSW_ASSERT_IMPL(a_busy_has_batch, state_r != S_IDLE, desc_valid, "busy without a batch")
  `PSW_ASSERT_IMPL(a_pick_found, state_r == S_CALC1, best_vld_r, "scan found no record")
  `PSW_ASSERT_IMPL(a_scan_in_range, sv_r, sidx_r <= last_idx, "scan index past batch")
  `PSW_ASSERT_NEXT(a_pop_marks_end, desc_pop, out_valid_r && out_r.end_of_run && state_r == S_IDLE, "batch retired without final result")

endmodule

@@ bench/testbench.sv @@
module testbench;

  localparam int PROC_SLOTS = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 400;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  psw_pkg::in_req_t  in_req = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  psw_pkg::out_req_t out_req;

  // shadow copy of the batch being loaded
  psw_pkg::rec_t batch_table[PROC_SLOTS];
  int unsigned   batch_fill = 0;
  bit            batch_lost = 1'b0;

  // schedule entries still owed by the block, oldest first
  psw_pkg::out_req_t schedule_q[$];

  // random idling on both channels while set
  bit idle_on = 1'b1;

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned records_sent = 0;
  int unsigned batches_done = 0;
  int unsigned overflow_batches = 0;
  int unsigned entries_checked = 0;

  priority_schedule_waiting_times_unit #(.MAX_PROCS(PROC_SLOTS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_req  (out_req)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // time sums clamp at the 24-bit maximum
  function automatic logic [23:0] clamp_ticks(input longint unsigned v);
    return (v > 64'hFFFFFF) ? 24'hFFFFFF : v[23:0];
  endfunction

  // load one record; on the last one, sort the batch and queue its schedule
  function automatic void predict_schedule(input psw_pkg::in_req_t rec);
    int unsigned       order[PROC_SLOTS];
    int unsigned       n;
    int unsigned       j;
    longint unsigned   busy_until;
    longint unsigned   start_t;
    longint unsigned   wait_t;
    psw_pkg::rec_t     prev;
    psw_pkg::rec_t     cur;
    psw_pkg::out_req_t res;
    if (batch_fill < PROC_SLOTS) begin
      batch_table[batch_fill] = '{id: rec.proc_id, arrive: rec.arrive_at,
                                  run: rec.run_length, prio: rec.prio_level};
      batch_fill++;
    end else begin
      // table full: record is lost, even when it is the last one
      batch_lost = 1'b1;
    end
    if (!rec.is_last) return;
    n = batch_fill;
    // stable insertion sort: lower prio, then earlier arrival, then load order
    for (int unsigned i = 0; i < n; i++) begin
      j = i;
      while (j > 0) begin
        prev = batch_table[order[j-1]];
        if (prev.prio < batch_table[i].prio ||
            (prev.prio == batch_table[i].prio &&
             prev.arrive <= batch_table[i].arrive)) break;
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    // run back to back; a process never starts before it arrives
    busy_until = 0;
    for (int unsigned k = 0; k < n; k++) begin
      cur = batch_table[order[k]];
      start_t = (busy_until > cur.arrive) ? busy_until : cur.arrive;
      wait_t = start_t - cur.arrive;
      busy_until = 64'(clamp_ticks(start_t + cur.run));
      res.out_id           = cur.id;
      res.out_arrive       = cur.arrive;
      res.out_run          = cur.run;
      res.out_prio         = cur.prio;
      res.wait_ticks       = wait_t[23:0];
      res.turnaround_ticks = clamp_ticks(wait_t + cur.run);
      res.dropped_flag     = batch_lost;
      res.end_of_run       = (k + 1 == n);
      schedule_q.push_back(res);
    end
    if (batch_lost) overflow_batches++;
    batches_done++;
    batch_fill = 0;
    batch_lost = 1'b0;
  endfunction

  // present one request, hold it until accepted, then update the prediction
  task automatic send_record(input psw_pkg::in_req_t rec);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= rec;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_schedule(rec);
    records_sent++;
  endtask

  // stop sending and wait until every owed entry has come out
  task automatic wait_for_schedule_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (schedule_q.size() != 0) @(posedge clk);
  endtask

  // random record; arrival, run length and priority are each narrowed half the time to force ties
  function automatic psw_pkg::in_req_t random_record(input bit last);
    psw_pkg::in_req_t rec;
    rec.proc_id    = 8'($urandom_range(0, 255));
    rec.arrive_at  = 16'($urandom_range(0, 1) ? $urandom_range(0, 15)
                                              : $urandom_range(0, 65535));
    rec.run_length = 16'($urandom_range(0, 1) ? $urandom_range(0, 15)
                                              : $urandom_range(0, 65535));
    rec.prio_level = 8'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                             : $urandom_range(0, 255));
    rec.is_last    = last;
    return rec;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // single-record batches at both ends of every field
  task automatic test_single_extremes();
    send_record('{8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1});
    send_record('{8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1});
  endtask

  // priority order, arrival tie-break, load-order tie-break, zero burst
  task automatic test_priority_order();
    send_record('{8'd1, 16'd0,   16'd10,    8'd5, 1'b0});
    send_record('{8'd2, 16'd3,   16'd4,     8'd2, 1'b0});
    send_record('{8'd3, 16'd3,   16'd0,     8'd2, 1'b0});
    send_record('{8'd4, 16'd1,   16'd6,     8'd2, 1'b0});
    send_record('{8'd5, 16'd500, 16'd7,     8'd9, 1'b0});
    send_record('{8'd6, 16'd0,   16'hFFFF,  8'd0, 1'b1});
  endtask

  // one record past the table size; the dropped one is the last request
  task automatic test_table_overflow();
    for (int unsigned s = 0; s <= PROC_SLOTS; s++)
      send_record(random_record(s == PROC_SLOTS));
  endtask

  // the sender holds off until the whole schedule has drained
  task automatic test_pause_for_drain();
    for (int unsigned s = 0; s < 4; s++)
      send_record(random_record(s == 3));
    wait_for_schedule_drain();
    for (int unsigned s = 0; s < 3; s++)
      send_record(random_record(s == 2));
  endtask

  // random batches, mostly short, sometimes full or overflowing
  task automatic test_random_batches(input int unsigned item_goal, input bit allow_idle);
    int unsigned sent;
    int unsigned size;
    sent = 0;
    while (sent < item_goal) begin
      idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(PROC_SLOTS, PROC_SLOTS + 3)
                                         : $urandom_range(1, 8);
      for (int unsigned s = 0; s < size; s++)
        send_record(random_record(s + 1 == size));
      sent += size;
    end
  endtask

  // result side: ready drops in random bursts while idling is on
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // every accepted request on the result side is matched with the oldest entry owed
  always @(posedge clk) begin : check_results
    psw_pkg::out_req_t want;
    if (rst_n && out_valid && out_ready) begin
      if (schedule_q.size() == 0) begin
        $error("schedule entry with none owed: id %0h", out_req.out_id);
        mismatch_count++;
      end else begin
        want = schedule_q.pop_front();
        check_field("out_id",           want.out_id,           out_req.out_id);
        check_field("out_arrive",       want.out_arrive,       out_req.out_arrive);
        check_field("out_run",          want.out_run,          out_req.out_run);
        check_field("out_prio",         want.out_prio,         out_req.out_prio);
        check_field("wait_ticks",       want.wait_ticks,       out_req.wait_ticks);
        check_field("turnaround_ticks", want.turnaround_ticks, out_req.turnaround_ticks);
        check_field("dropped_flag",     want.dropped_flag,     out_req.dropped_flag);
        check_field("end_of_run",       want.end_of_run,       out_req.end_of_run);
        entries_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d entries still owed",
               cycle_count, schedule_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_single_extremes();
    test_priority_order();
    test_table_overflow();
    test_pause_for_drain();
    test_random_batches(100, 1'b1);
    // closing stretch with both sides running flat out
    test_random_batches(25, 1'b0);
    wait_for_schedule_drain();
    // catch any stray entries after the last one owed
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d process records in %0d batches, %0d of them over capacity",
             records_sent, batches_done, overflow_batches);
    $display("checked %0d schedule entries in %0d cycles", entries_checked, cycle_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
